/* rtl/sem_pkg.sv */
// Shared types and constants for the Sobel edge magnitude stream.
// Depends on nothing; every other file of the block imports it.
package sem_pkg;

	// Line store geometry.
	localparam int MAX_WIDTH = 8192;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	// Field and register widths.
	localparam int PIX_W        = 8;
	localparam int WIDTH_REG_W  = 14;
	localparam int HEIGHT_REG_W = 16;
	localparam int ROW_W        = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Register reset values.
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 14'd1920;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1080;

	// Largest magnitude that leaves the block.
	localparam logic [PIX_W-1:0] MAG_MAX = 8'hFF;

	typedef logic [PIX_W-1:0] pix_t;

	// One accepted item with its position decisions, from the counters to the line stores.
	typedef struct packed {
		pix_t             pixel;
		logic [COL_W-1:0] col;
		logic             row0;        // first row of the frame: column is the pixel itself
		logic             center_top;  // centre row is row 0: top replicates the centre
		logic             bottom;      // centre row is the last row: bottom replicates it
		logic             emit;        // this transaction releases a result
		logic             col0;        // result uses the window before the shift
		logic             col1;        // left edge replicated
		logic             width1;      // one-pixel rows
		logic             eor;
		logic             eof;
	} item_t;

	// Three window columns of a result, index 0 top, 1 middle, 2 bottom.
	typedef struct packed {
		logic [2:0][PIX_W-1:0] left;
		logic [2:0][PIX_W-1:0] center;
		logic [2:0][PIX_W-1:0] right;
		logic                  eor;
		logic                  eof;
	} cols_t;

endpackage

/* rtl/sem_stream_if.sv */
// Valid/ready stream interfaces for pixel input and magnitude output.
// Depends on sem_pkg for the payload types.
interface sem_pix_if;
	import sem_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel;
	logic flush;

	modport source (output valid, pixel, flush, input ready);
	modport sink (input valid, pixel, flush, output ready);
endinterface

interface sem_mag_if;
	import sem_pkg::*;

	logic valid;
	logic ready;
	pix_t magnitude;
	logic end_of_row;
	logic end_of_frame;

	modport source (output valid, magnitude, end_of_row, end_of_frame, input ready);
	modport sink (input valid, magnitude, end_of_row, end_of_frame, output ready);
endinterface

/* rtl/sem_ctrl.sv */
// Configuration registers and raster position counters of the input and output side.
// Depends on sem_pkg and sem_pix_if.
module sem_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [sem_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]  wr_data,
	sem_pix_if.sink                         pix_in,
	input  logic                            item_ready,
	output logic                            item_valid,
	output sem_pkg::item_t                  item
);
	import sem_pkg::*;

	logic [WIDTH_REG_W-1:0]  width_cfg_q;
	logic [HEIGHT_REG_W-1:0] height_cfg_q;
	logic [ROW_W-1:0]        in_row_q;
	logic [COL_W-1:0]        in_col_q;
	logic [ROW_W-1:0]        out_row_q;
	logic [COL_W-1:0]        out_col_q;

	logic [COL_W:0]          eff_w;
	logic [HEIGHT_REG_W-1:0] eff_h;
	logic [COL_W:0]          in_col_inc;
	logic [COL_W:0]          out_col_inc;
	logic [ROW_W:0]          out_row_inc;
	logic                    emit;
	logic                    eor;
	logic                    eof;
	logic                    accept;

	// Effective frame size: zero counts as one, the width is capped at the line store depth.
	always_comb begin
		if (width_cfg_q == '0) begin
			eff_w = (COL_W+1)'(1);
		end else if (32'(width_cfg_q) > 32'(MAX_WIDTH)) begin
			eff_w = (COL_W+1)'(MAX_WIDTH);
		end else begin
			eff_w = (COL_W+1)'(width_cfg_q);
		end
		eff_h = (height_cfg_q == '0) ? HEIGHT_REG_W'(1) : height_cfg_q;
	end

	// Position decisions for the transaction at the input.
	always_comb begin
		in_col_inc  = {1'b0, in_col_q} + (COL_W+1)'(1);
		out_col_inc = {1'b0, out_col_q} + (COL_W+1)'(1);
		out_row_inc = {1'b0, out_row_q} + (ROW_W+1)'(1);
		emit = (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && in_col_q != '0);
		eor  = emit && (out_col_inc >= eff_w);
		eof  = eor && (out_row_inc >= {1'b0, eff_h});

		item.pixel      = pix_in.flush ? '0 : pix_in.pixel;
		item.col        = in_col_q;
		item.row0       = (in_row_q == '0);
		item.center_top = (in_row_q == ROW_W'(1));
		item.bottom     = (in_row_q >= eff_h);
		item.emit       = emit;
		item.col0       = (in_col_q == '0);
		item.col1       = (in_col_q == COL_W'(1));
		item.width1     = (eff_w == (COL_W+1)'(1));
		item.eor        = eor;
		item.eof        = eof;
	end

	assign item_valid   = pix_in.valid;
	assign pix_in.ready = item_ready;
	assign accept       = pix_in.valid && item_ready;

	// Registers and counters; a register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= WIDTH_RESET;
			height_cfg_q <= HEIGHT_RESET;
			in_row_q     <= '0;
			in_col_q     <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_WIDTH: begin
					width_cfg_q <= wr_data[WIDTH_REG_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					height_cfg_q <= wr_data[HEIGHT_REG_W-1:0];
				end
				default: begin
				end
			endcase
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (accept) begin
			if (eof) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				if (eor) begin
					out_col_q <= '0;
					out_row_q <= out_row_inc[ROW_W-1:0];
				end else if (emit) begin
					out_col_q <= out_col_inc[COL_W-1:0];
				end
				if (in_col_inc >= eff_w) begin
					in_col_q <= '0;
					if (in_row_q != '1) begin
						in_row_q <= in_row_q + ROW_W'(1);
					end
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
			end
		end
	end

endmodule

/* rtl/sem_line_buf.sv */
// Two row memories with read-modify-write and forwarding, plus the sliding 3x3 window.
// Depends on sem_pkg.
module sem_line_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           restart,
	input  logic           item_valid,
	input  sem_pkg::item_t item,
	output logic           item_ready,
	output logic           cols_valid,
	output sem_pkg::cols_t cols,
	input  logic           cols_ready
);
	import sem_pkg::*;

	// Row memories, one entry per column.
	pix_t older_mem [MAX_WIDTH];
	pix_t newer_mem [MAX_WIDTH];

	logic  v_s1;
	item_t item_s1;
	pix_t  older_rd_s1;
	pix_t  newer_rd_s1;
	logic  older_fwd_s1;
	logic  newer_fwd_s1;
	pix_t  older_fwd_data_s1;
	pix_t  newer_fwd_data_s1;

	// Window columns: centre and right; the left one drops out on each shift.
	logic [2:0][PIX_W-1:0] win_c_q;
	logic [2:0][PIX_W-1:0] win_r_q;

	logic                  accept;
	logic                  proc;
	pix_t                  older_rd;
	pix_t                  newer_rd;
	logic [2:0][PIX_W-1:0] new_col;
	logic                  older_we;
	logic                  left_is_r;

	assign accept     = item_valid && item_ready;
	assign proc       = v_s1 && (!item_s1.emit || cols_ready);
	assign item_ready = !v_s1 || proc;
	assign cols_valid = v_s1 && item_s1.emit;
	assign older_we   = proc && !item_s1.row0;

	// Read data, replaced by the write of the same cycle when the addresses matched.
	assign older_rd = older_fwd_s1 ? older_fwd_data_s1 : older_rd_s1;
	assign newer_rd = newer_fwd_s1 ? newer_fwd_data_s1 : newer_rd_s1;

	// New column with the row mux at the top and bottom edges.
	always_comb begin
		if (item_s1.row0) begin
			new_col[0] = item_s1.pixel;
			new_col[1] = item_s1.pixel;
			new_col[2] = item_s1.pixel;
		end else begin
			new_col[1] = newer_rd;
			new_col[0] = item_s1.center_top ? newer_rd : older_rd;
			new_col[2] = item_s1.bottom ? newer_rd : item_s1.pixel;
		end
	end

	// Column selection; the row's first column closes the previous row with the old window.
	always_comb begin
		left_is_r   = item_s1.col0 ? item_s1.width1 : item_s1.col1;
		cols.left   = left_is_r ? win_r_q : win_c_q;
		cols.center = win_r_q;
		cols.right  = item_s1.col0 ? win_r_q : new_col;
		cols.eor    = item_s1.eor;
		cols.eof    = item_s1.eof;
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (proc) begin
			v_s1 <= 1'b0;
		end
	end

	// Memory reads with forwarding capture, loaded together with the stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1           <= item;
			older_rd_s1       <= older_mem[item.col];
			newer_rd_s1       <= newer_mem[item.col];
			older_fwd_s1      <= older_we && (item_s1.col == item.col);
			newer_fwd_s1      <= proc && (item_s1.col == item.col);
			older_fwd_data_s1 <= new_col[1];
			newer_fwd_data_s1 <= item_s1.pixel;
		end
	end

	// Write back: the middle row moves to the older store, the pixel to the newer one.
	always_ff @(posedge clk) begin
		if (older_we) begin
			older_mem[item_s1.col] <= new_col[1];
		end
		if (proc) begin
			newer_mem[item_s1.col] <= item_s1.pixel;
		end
	end

	// Window shift, cleared at frame end and on a register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_c_q <= '0;
			win_r_q <= '0;
		end else if (restart) begin
			win_c_q <= '0;
			win_r_q <= '0;
		end else if (proc) begin
			if (item_s1.eof) begin
				win_c_q <= '0;
				win_r_q <= '0;
			end else begin
				win_c_q <= win_r_q;
				win_r_q <= new_col;
			end
		end
	end

endmodule

/* rtl/sem_grad.sv */
// Sobel gradient pipeline: column register, Gx/Gy sums, L1 magnitude with saturation.
// Depends on sem_pkg and sem_mag_if.
module sem_grad (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cols_valid,
	input  sem_pkg::cols_t cols,
	output logic           cols_ready,
	sem_mag_if.source      mag_out
);
	import sem_pkg::*;

	localparam int GRAD_W = PIX_W + 3;

	logic                     v_s2;
	cols_t                    cols_s2;
	logic                     v_s3;
	logic signed [GRAD_W-1:0] gx_s3;
	logic signed [GRAD_W-1:0] gy_s3;
	logic                     eor_s3;
	logic                     eof_s3;
	logic                     out_valid_q;
	pix_t                     mag_q;
	logic                     eor_q;
	logic                     eof_q;

	logic                     ready_o;
	logic                     ready_s3;
	logic                     ready_s2;
	logic signed [GRAD_W-1:0] gx;
	logic signed [GRAD_W-1:0] gy;
	logic [GRAD_W-1:0]        abs_gx;
	logic [GRAD_W-1:0]        abs_gy;
	logic [GRAD_W-1:0]        sum;
	pix_t                     mag;

	function automatic logic signed [GRAD_W-1:0] ext(input pix_t p);
		return signed'({3'b000, p});
	endfunction

	// Each stage loads when it is empty or its contents move on.
	assign ready_o    = !out_valid_q || mag_out.ready;
	assign ready_s3   = !v_s3 || ready_o;
	assign ready_s2   = !v_s2 || ready_s3;
	assign cols_ready = ready_s2;

	// Gradient sums over the registered columns.
	always_comb begin
		gx = (ext(cols_s2.right[0]) - ext(cols_s2.left[0]))
			+ ((ext(cols_s2.right[1]) - ext(cols_s2.left[1])) <<< 1)
			+ (ext(cols_s2.right[2]) - ext(cols_s2.left[2]));
		gy = (ext(cols_s2.left[2]) - ext(cols_s2.left[0]))
			+ ((ext(cols_s2.center[2]) - ext(cols_s2.center[0])) <<< 1)
			+ (ext(cols_s2.right[2]) - ext(cols_s2.right[0]));
	end

	// L1 magnitude, saturated to the pixel range.
	always_comb begin
		abs_gx = gx_s3[GRAD_W-1] ? GRAD_W'(-gx_s3) : GRAD_W'(gx_s3);
		abs_gy = gy_s3[GRAD_W-1] ? GRAD_W'(-gy_s3) : GRAD_W'(gy_s3);
		sum    = abs_gx + abs_gy;
		mag    = (sum > GRAD_W'(MAG_MAX)) ? MAG_MAX : sum[PIX_W-1:0];
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s2) begin
				v_s2 <= cols_valid;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
			if (ready_o) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (ready_s2 && cols_valid) begin
			cols_s2 <= cols;
		end
		if (ready_s3 && v_s2) begin
			gx_s3  <= gx;
			gy_s3  <= gy;
			eor_s3 <= cols_s2.eor;
			eof_s3 <= cols_s2.eof;
		end
		if (ready_o && v_s3) begin
			mag_q <= mag;
			eor_q <= eor_s3;
			eof_q <= eof_s3;
		end
	end

	assign mag_out.valid        = out_valid_q;
	assign mag_out.magnitude    = mag_q;
	assign mag_out.end_of_row   = eor_q;
	assign mag_out.end_of_frame = eof_q;

endmodule

/* rtl/sobel_edge_magnitude_stream.sv */
// Streaming 3x3 Sobel edge magnitude, |Gx|+|Gy| saturated to 255, borders replicated.
// Throughput: one transaction per clock when the output is not stalled, set by the single
// read-modify-write per row memory. Latency: a pixel's result leaves with the transaction
// frame_width+1 later in the stream, through the stage, column, sum and output registers.
// Reset: registers return to 1920 x 1080, counters and window clear; row memories keep
// their contents and need no clearing pass, so input is taken right after reset.
module sobel_edge_magnitude_stream (
	input  logic                            clk,
	input  logic                            arst_n,
	sem_pix_if.sink                         pix_in,
	sem_mag_if.source                       mag_out,
	input  logic                            wr_en,
	input  logic [sem_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]  wr_data
);
	import sem_pkg::*;

	logic  item_valid;
	logic  item_ready;
	item_t item;
	logic  cols_valid;
	logic  cols_ready;
	cols_t cols;

	// Position counters and configuration.
	sem_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.pix_in     (pix_in),
		.item_ready (item_ready),
		.item_valid (item_valid),
		.item       (item)
	);

	// Row memories and window.
	sem_line_buf u_line_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (wr_en),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.cols_valid (cols_valid),
		.cols       (cols),
		.cols_ready (cols_ready)
	);

	// Gradient and magnitude pipeline.
	sem_grad u_grad (
		.clk        (clk),
		.arst_n     (arst_n),
		.cols_valid (cols_valid),
		.cols       (cols),
		.cols_ready (cols_ready),
		.mag_out    (mag_out)
	);

endmodule
